// File: rtl/assert_macros.svh
// assertion macros used by the core top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition that never holds outside reset
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");

`endif

// File: rtl/cspw_pkg.sv
// types, constants and the pole coefficient for the conic pole weight core
// no dependencies
package cspw_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int WEIGHT_FRAC_BITS = 24;
	localparam int FIFO_DEPTH       = 4;
	localparam int PTR_W            = $clog2(FIFO_DEPTH);
	localparam int CNT_W            = $clog2(FIFO_DEPTH + 3);

	localparam logic [31:0] W_SAT = 32'hFFFF_FFFF;
	localparam logic [31:0] W_ONE = 32'(64'd1 << WEIGHT_FRAC_BITS);

	localparam logic REQ_QUAD  = 1'b0;
	localparam logic REQ_QUART = 1'b1;

	// sqrt(27/32) in the weight format, rounded to nearest, elaboration only
	function automatic logic [63:0] pole_coeff_f();
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bitv;
		n    = 64'd27 << (2 * WEIGHT_FRAC_BITS - 5);
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bitv != 0 && bitv <= n || (bitv != 0 && res != 0)) begin
				if (n >= res + bitv) begin
					n   = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
			end
			bitv = bitv >> 2;
		end
		if (n > res) res = res + 64'd1;
		return res;
	endfunction

	localparam logic [31:0] W_COEFF = 32'(pole_coeff_f());

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one classified section waiting for the back end
	typedef struct packed {
		logic        req_type;
		logic        degen;
		coord_t      p0x, p0y, p1x, p1y, p2x, p2y;
		coord_t      r1x, r1y, r2x, r2y, r3x, r3y;
		logic [31:0] w;
		logic [31:0] c;
	} sect_t;

	// queue status seen by both sides
	typedef struct packed {
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

// File: rtl/cspw_front.sv
// front end: subdivision, degenerate test and weight product, two stages
// depends on cspw_pkg
module cspw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 req_type,
	input  cspw_pkg::coord_t     start_x, start_y, corner_x, corner_y, end_x, end_y,
	input  logic [31:0]          base_weight,
	output logic [1:0]           busy,
	output logic                 push,
	output cspw_pkg::sect_t      push_data
);
	import cspw_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	logic                 v_s1, v_s2;
	sect_t                sec_s1, sec_s2;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [2*DW-1:0] pa_s2, pb_s2;
	logic [63:0]          wp_s2;

	logic signed [DW-1:0]   s1x, s1y, s3x, s3y;
	logic signed [DW+3:0]   s2x, s2y;
	logic [32:0]            wr;

	// rounded midpoints, ties toward +infinity
	always_comb begin
		s1x = DW'(start_x) + DW'(corner_x) + DW'(1);
		s1y = DW'(start_y) + DW'(corner_y) + DW'(1);
		s3x = DW'(corner_x) + DW'(end_x) + DW'(1);
		s3y = DW'(corner_y) + DW'(end_y) + DW'(1);
		s2x = (DW+4)'(start_x) + (DW+4)'(corner_x) * 6 + (DW+4)'(end_x) + (DW+4)'(4);
		s2y = (DW+4)'(start_y) + (DW+4)'(corner_y) * 6 + (DW+4)'(end_y) + (DW+4)'(4);
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	// stage 1: points and edge vectors
	always_ff @(posedge clk) begin
		sec_s1.req_type <= req_type;
		sec_s1.degen    <= 1'b0;
		sec_s1.p0x <= start_x;  sec_s1.p0y <= start_y;
		sec_s1.p1x <= corner_x; sec_s1.p1y <= corner_y;
		sec_s1.p2x <= end_x;    sec_s1.p2y <= end_y;
		sec_s1.r1x <= coord_t'(s1x >>> 1); sec_s1.r1y <= coord_t'(s1y >>> 1);
		sec_s1.r3x <= coord_t'(s3x >>> 1); sec_s1.r3y <= coord_t'(s3y >>> 1);
		sec_s1.r2x <= coord_t'(s2x >>> 3); sec_s1.r2y <= coord_t'(s2y >>> 3);
		sec_s1.w   <= '0;
		sec_s1.c   <= '0;
		ax_s1 <= DW'(corner_x) - DW'(start_x);
		ay_s1 <= DW'(corner_y) - DW'(start_y);
		bx_s1 <= DW'(end_x) - DW'(start_x);
		by_s1 <= DW'(end_y) - DW'(start_y);
	end

	// stage 2: cross products and weight product
	always_ff @(posedge clk) begin
		sec_s2 <= sec_s1;
		pa_s2  <= ax_s1 * by_s1;
		pb_s2  <= ay_s1 * bx_s1;
		wp_s2  <= 64'(W_COEFF) * 64'(base_weight) + (64'd1 << (WEIGHT_FRAC_BITS - 1));
	end

	// classify and saturate
	always_comb begin
		wr        = 33'(wp_s2 >> WEIGHT_FRAC_BITS);
		push_data = sec_s2;
		push_data.degen = (pa_s2 == pb_s2);
		if (pa_s2 == pb_s2) begin
			push_data.c = W_SAT;
			push_data.w = W_SAT;
		end else begin
			push_data.c = W_COEFF;
			push_data.w = wr[32] ? W_SAT : wr[31:0];
		end
	end

	assign push = v_s2;
	assign busy = {v_s2, v_s1};

endmodule

// File: rtl/cspw_fifo.sv
// short section queue between front and back end
// depends on cspw_pkg
module cspw_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cspw_pkg::sect_t       push_data,
	input  logic                  pop,
	output cspw_pkg::sect_t       head,
	output cspw_pkg::fifo_stat_t  stat
);
	import cspw_pkg::*;

	sect_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= PTR_W'((32'(wp_q) + 1) % FIFO_DEPTH);
			if (pop)  rp_q <= PTR_W'((32'(rp_q) + 1) % FIFO_DEPTH);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign head       = mem_q[rp_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(FIFO_DEPTH));

endmodule

// File: rtl/cspw_back.sv
// back end: walks one queued section pole by pole into the output register
// depends on cspw_pkg
module cspw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cspw_pkg::sect_t       head,
	input  logic                  empty,
	input  logic [31:0]           base_weight,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [2:0]            pole_index,
	output cspw_pkg::coord_t      pole_x,
	output cspw_pkg::coord_t      pole_y,
	output logic [31:0]           pole_weight,
	output logic [31:0]           weight_coeff,
	output logic                  last_pole,
	output logic                  degenerate
);
	import cspw_pkg::*;

	logic [2:0]  idx_q;
	logic        ov_q;
	logic        load, last;
	coord_t      sx, sy;
	logic [31:0] sw, sc;

	assign load = !ov_q || !out_stall;
	assign last = (head.req_type == REQ_QUART) ? (idx_q == 3'd4) : (idx_q == 3'd2);
	assign pop  = load && !empty && last;

	// pole select
	always_comb begin
		sx = head.p0x; sy = head.p0y; sw = W_ONE; sc = W_ONE;
		if (head.req_type == REQ_QUAD) begin
			unique case (idx_q)
				3'd1: begin sx = head.p1x; sy = head.p1y; sw = base_weight; end
				3'd2: begin sx = head.p2x; sy = head.p2y; end
				default: ;
			endcase
		end else begin
			unique case (idx_q)
				3'd1: begin sx = head.r1x; sy = head.r1y; sw = head.w; sc = head.c; end
				3'd2: begin sx = head.r2x; sy = head.r2y; sw = base_weight; end
				3'd3: begin sx = head.r3x; sy = head.r3y; sw = head.w; sc = head.c; end
				3'd4: begin sx = head.p2x; sy = head.p2y; end
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			ov_q <= !empty;
			if (!empty) idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			pole_index   <= idx_q;
			pole_x       <= sx;
			pole_y       <= sy;
			pole_weight  <= sw;
			weight_coeff <= sc;
			last_pole    <= last;
			degenerate   <= (head.req_type == REQ_QUART) && head.degen;
		end
	end

	assign out_valid = ov_q;

endmodule

// File: rtl/conic_section_pole_weights_core.sv
// channel   dir  handshake          payload
// in        in   in_valid/in_stall   req_type, start/corner/end x,y
// out       out  out_valid/out_stall pole_index, pole_x/y, weights, marks
// cfg       in   cfg_valid/cfg_ready cfg_data (base_weight)
// a request yields three poles (quadratic) or five (quartic), set by the back end walk
// from accept the first pole passes the two front stages, the queue and the back end output register
// reset clears the queue and restores base_weight to 1.0
// the front stalls once queued plus in-flight sections fill the four-entry queue
// depends on cspw_pkg, cspw_front, cspw_fifo, cspw_back, assert_macros.svh
`include "assert_macros.svh"
module conic_section_pole_weights_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  cspw_pkg::coord_t      start_x,
	input  cspw_pkg::coord_t      start_y,
	input  cspw_pkg::coord_t      corner_x,
	input  cspw_pkg::coord_t      corner_y,
	input  cspw_pkg::coord_t      end_x,
	input  cspw_pkg::coord_t      end_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            pole_index,
	output cspw_pkg::coord_t      pole_x,
	output cspw_pkg::coord_t      pole_y,
	output logic [31:0]           pole_weight,
	output logic [31:0]           weight_coeff,
	output logic                  last_pole,
	output logic                  degenerate,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [31:0]           cfg_data
);
	import cspw_pkg::*;

	logic [31:0] base_weight_q;
	logic [1:0]  busy;
	logic        push, pop, acc;
	sect_t       push_data, head;
	fifo_stat_t  stat;

	// base weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_weight_q <= W_ONE;
		else if (cfg_valid && cfg_ready) base_weight_q <= cfg_data;
	end
	assign cfg_ready = 1'b1;

	// credit check against queue space
	assign in_stall = (stat.count + CNT_W'(busy[0]) + CNT_W'(busy[1])) >= CNT_W'(FIFO_DEPTH);
	assign acc      = in_valid && !in_stall;

	cspw_front u_front (
		.clk, .arst_n, .acc, .req_type, .start_x, .start_y, .corner_x, .corner_y,
		.end_x, .end_y, .base_weight(base_weight_q), .busy, .push, .push_data
	);

	cspw_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .head, .stat
	);

	cspw_back u_back (
		.clk, .arst_n, .head, .empty(stat.empty), .base_weight(base_weight_q), .pop,
		.out_stall, .out_valid, .pole_index, .pole_x, .pole_y, .pole_weight,
		.weight_coeff, .last_pole, .degenerate
	);

	// checks
	`ASSERT_NEVER(a_no_overflow, push && stat.full && !pop)
	`ASSERT_NEVER(a_no_underflow, pop && stat.empty)
	`ASSERT_IMPL(a_last_index, out_valid && last_pole, pole_index == 3'd2 || pole_index == 3'd4)

endmodule
